FILE: hdl/sa_kth_pkg.sv
`default_nettype none

package sa_kth_pkg;

    localparam int MAX_TEXT = 1024;
    localparam int ALPHABET = 26;
    localparam int NST      = 2 * MAX_TEXT;
    localparam int ST_W     = $clog2(NST);
    localparam int LEN_W    = $clog2(MAX_TEXT + 1);
    localparam int SC_W     = $clog2(NST + 1);
    localparam int BKT_N    = MAX_TEXT + 2;
    localparam int BKT_AW   = $clog2(BKT_N);
    localparam int RANK_W   = 20;
    localparam int LET_W    = 5;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 3;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd3;

    localparam logic [STAT_W-1:0] ST_ACK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_LETTER  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOSUCH  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOQUERY = 3'd4;

    typedef logic [ALPHABET-1:0][ST_W-1:0] row_t;

endpackage

`default_nettype wire

FILE: hdl/suffix_automaton_kth_substring.sv
// Channel   Dir  tdata                              tuser        tlast
// s_        in   [4:0] letter, [24:5] rank_k        kind         -
// m_        out  [4:0] out_letter                   status       last_letter
// cfg_      in   cfg_wdata = count_mode             -            -
// Append: walks the suffix links one step at a time, one transition row per cycle, and clones a state
// when the lengths do not match.
// Query start with stale counts: a recount first, by walks over the bucket, order, occurrence and
// path memories, each with one read port and one write port.
// Next query letter: a scan of the current state's transition row in letter order. Clear and reset:
// one transition row a cycle; s_tready stays low meanwhile. A result waits in the output register.
`default_nettype none

module suffix_automaton_kth_substring (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire                              cfg_wdata,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [31:0]                      s_tdata,   // [4:0] letter, [24:5] rank_k
    input  wire  [sa_kth_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,   // [4:0] out_letter
    output logic [sa_kth_pkg::STAT_W-1:0]    m_tuser,   // [2:0] status
    output logic                             m_tlast
);

    localparam int ST_W   = sa_kth_pkg::ST_W;
    localparam int LEN_W  = sa_kth_pkg::LEN_W;
    localparam int SC_W   = sa_kth_pkg::SC_W;
    localparam int BKT_AW = sa_kth_pkg::BKT_AW;
    localparam int RANK_W = sa_kth_pkg::RANK_W;
    localparam int LET_W  = sa_kth_pkg::LET_W;
    localparam int STAT_W = sa_kth_pkg::STAT_W;
    localparam int KIND_W = sa_kth_pkg::KIND_W;
    localparam int NST    = sa_kth_pkg::NST;
    localparam int BKT_N  = sa_kth_pkg::BKT_N;

    localparam logic [5:0] S_IDLE = 6'd0,  S_CLR  = 6'd1,  S_DONE = 6'd2,  S_APLEN = 6'd3,
                           S_W1   = 6'd4,  S_HIT2 = 6'd5,  S_HIT3 = 6'd6,  S_CL2   = 6'd7,
                           S_R2   = 6'd8,  S_CLF  = 6'd9,  S_CLF2 = 6'd10, S_APEND = 6'd11,
                           S_BCLR = 6'd12, S_BLEN = 6'd13, S_BBRD = 6'd14, S_BBWR  = 6'd15,
                           S_PRD  = 6'd16, S_PWR  = 6'd17, S_OLEN = 6'd18, S_OBRD  = 6'd19,
                           S_OWR  = 6'd20, S_ILEN = 6'd21, S_IWR  = 6'd22, S_CORD  = 6'd23,
                           S_COCC = 6'd24, S_CLNK = 6'd25, S_CWR  = 6'd26, S_TORD  = 6'd27,
                           S_TROW = 6'd28, S_TINI = 6'd29, S_TLP  = 6'd30, S_TADD  = 6'd31,
                           S_QRD  = 6'd32, S_QCHK = 6'd33, S_NROW = 6'd34, S_NLP   = 6'd35,
                           S_NCHK = 6'd36;

    // memories
    logic [LEN_W:0]            len_mem  [NST];
    logic [ST_W-1:0]           link_mem [NST];
    sa_kth_pkg::row_t          trans_mem[NST];
    logic [LEN_W-1:0]          occ_mem  [NST];
    logic [RANK_W-1:0]         path_mem [NST];
    logic [ST_W-1:0]           ord_mem  [NST];
    logic [SC_W-1:0]           bkt_mem  [BKT_N];

    logic                      len_we, link_we, trans_we, occ_we, path_we, ord_we, bkt_we;
    logic [ST_W-1:0]           len_wa, link_wa, trans_wa, occ_wa, path_wa, ord_wa;
    logic [ST_W-1:0]           len_ra, link_ra, trans_ra, occ_ra, path_ra, ord_ra;
    logic [BKT_AW-1:0]         bkt_wa, bkt_ra;
    logic [LEN_W:0]            len_wd, len_rd;
    logic [ST_W-1:0]           link_wd, link_rd, ord_wd, ord_rd;
    sa_kth_pkg::row_t          trans_wd, trans_rd;
    logic [LEN_W-1:0]          occ_wd, occ_rd;
    logic [RANK_W-1:0]         path_wd, path_rd;
    logic [SC_W-1:0]           bkt_wd, bkt_rd;

    always_ff @(posedge aclk) begin
        if (len_we) len_mem[len_wa] <= len_wd;
        len_rd <= len_mem[len_ra];
        if (link_we) link_mem[link_wa] <= link_wd;
        link_rd <= link_mem[link_ra];
        if (trans_we) trans_mem[trans_wa] <= trans_wd;
        trans_rd <= trans_mem[trans_ra];
        if (occ_we) occ_mem[occ_wa] <= occ_wd;
        occ_rd <= occ_mem[occ_ra];
        if (path_we) path_mem[path_wa] <= path_wd;
        path_rd <= path_mem[path_ra];
        if (ord_we) ord_mem[ord_wa] <= ord_wd;
        ord_rd <= ord_mem[ord_ra];
        if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
        bkt_rd <= bkt_mem[bkt_ra];
    end

    logic [5:0]               st_reg, st_next;
    logic                     mode_reg, mode_next;
    logic [LEN_W-1:0]         tl_reg, tl_next;
    logic [SC_W-1:0]          sc_reg, sc_next;
    logic [ST_W-1:0]          last_reg, last_next;
    logic                     stale_reg, stale_next;
    logic [ST_W-1:0]          qcur_reg, qcur_next;
    logic [RANK_W:0]          qsum_reg, qsum_next;
    logic [RANK_W-1:0]        qrank_reg, qrank_next;
    logic                     qact_reg, qact_next;
    logic                     resp_reg, resp_next;
    logic [LET_W-1:0]         let_reg, let_next;
    logic [RANK_W-1:0]        rank_reg, rank_next;
    logic [ST_W-1:0]          cur_reg, cur_next;
    logic [ST_W-1:0]          u_reg, u_next;
    logic [ST_W-1:0]          v_reg, v_next;
    logic [ST_W-1:0]          w_reg, w_next;
    logic [LEN_W-1:0]         lenv_reg, lenv_next;
    logic [SC_W-1:0]          idx_reg, idx_next;
    logic [RANK_W-1:0]        acc_reg, acc_next;
    logic [SC_W-1:0]          run_reg, run_next;
    logic [LET_W-1:0]         c_reg, c_next;
    sa_kth_pkg::row_t         row_reg, row_next;
    logic [LEN_W-1:0]         occu_reg, occu_next;
    logic [ST_W-1:0]          lnk_reg, lnk_next;
    logic [STAT_W-1:0]        rs_reg, rs_next;
    logic [LET_W-1:0]         rl_reg, rl_next;
    logic                     rlast_reg, rlast_next;
    logic                     mv_reg, mv_next;
    logic [STAT_W-1:0]        mu_reg, mu_next;
    logic [LET_W-1:0]         md_reg, md_next;
    logic                     ml_reg, ml_next;

    logic [RANK_W:0]          sum1, sum2;
    logic [SC_W-1:0]          psum;

    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser  = mu_reg;
    assign m_tdata  = {{(8 - LET_W){1'b0}}, md_reg};
    assign m_tlast  = ml_reg;

    assign sum1 = qsum_reg + {1'b0, path_rd};
    assign sum2 = qsum_reg + (mode_reg ? (RANK_W + 1)'(1) : (RANK_W + 1)'(occ_rd));
    assign psum = bkt_rd + run_reg;

    always_comb begin
        st_next = st_reg;       mode_next = mode_reg;   tl_next = tl_reg;
        sc_next = sc_reg;       last_next = last_reg;   stale_next = stale_reg;
        qcur_next = qcur_reg;   qsum_next = qsum_reg;   qrank_next = qrank_reg;
        qact_next = qact_reg;   resp_next = resp_reg;   let_next = let_reg;
        rank_next = rank_reg;   cur_next = cur_reg;     u_next = u_reg;
        v_next = v_reg;         w_next = w_reg;         lenv_next = lenv_reg;
        idx_next = idx_reg;     acc_next = acc_reg;     run_next = run_reg;
        c_next = c_reg;         row_next = row_reg;     occu_next = occu_reg;
        lnk_next = lnk_reg;     rs_next = rs_reg;       rl_next = rl_reg;
        rlast_next = rlast_reg; mu_next = mu_reg;       md_next = md_reg;
        ml_next = ml_reg;
        mv_next = mv_reg & ~m_tready;

        len_we = 1'b0;   len_wa = '0;   len_wd = '0;   len_ra = '0;
        link_we = 1'b0;  link_wa = '0;  link_wd = '0;  link_ra = '0;
        trans_we = 1'b0; trans_wa = '0; trans_wd = '0; trans_ra = '0;
        occ_we = 1'b0;   occ_wa = '0;   occ_wd = '0;   occ_ra = '0;
        path_we = 1'b0;  path_wa = '0;  path_wd = '0;  path_ra = '0;
        ord_we = 1'b0;   ord_wa = '0;   ord_wd = '0;   ord_ra = '0;
        bkt_we = 1'b0;   bkt_wa = '0;   bkt_wd = '0;   bkt_ra = '0;

        case (st_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    let_next = s_tdata[LET_W-1:0];
                    rank_next = s_tdata[LET_W+RANK_W-1:LET_W];
                    rs_next = sa_kth_pkg::ST_ACK;
                    rl_next = '0;
                    rlast_next = 1'b0;
                    case (s_tuser)
                        sa_kth_pkg::KIND_CLEAR: begin
                            idx_next = '0;
                            resp_next = 1'b1;
                            st_next = S_CLR;
                        end
                        sa_kth_pkg::KIND_APPEND: begin
                            if (tl_reg == LEN_W'(sa_kth_pkg::MAX_TEXT)) begin
                                rs_next = sa_kth_pkg::ST_FULL;
                                st_next = S_DONE;
                            end else if (s_tdata[LET_W-1:0] >= LET_W'(sa_kth_pkg::ALPHABET)) begin
                                st_next = S_DONE;
                            end else begin
                                len_ra = last_reg;
                                st_next = S_APLEN;
                            end
                        end
                        sa_kth_pkg::KIND_START: begin
                            qact_next = 1'b0;
                            if (stale_reg) begin
                                idx_next = '0;
                                st_next = S_BCLR;
                            end else begin
                                path_ra = '0;
                                st_next = S_QCHK;
                            end
                        end
                        default: begin
                            if (!qact_reg) begin
                                rs_next = sa_kth_pkg::ST_NOQUERY;
                                st_next = S_DONE;
                            end else begin
                                trans_ra = qcur_reg;
                                st_next = S_NROW;
                            end
                        end
                    endcase
                end
            end
            S_CLR: begin
                trans_we = 1'b1;
                trans_wa = idx_reg[ST_W-1:0];
                if (idx_reg == '0) begin
                    len_we = 1'b1;
                    path_we = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SC_W'(NST - 1)) begin
                    tl_next = '0;
                    sc_next = SC_W'(1);
                    last_next = '0;
                    stale_next = 1'b0;
                    qcur_next = '0;
                    qsum_next = '0;
                    qrank_next = '0;
                    qact_next = 1'b0;
                    st_next = resp_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    mu_next = rs_reg;
                    md_next = rl_reg;
                    ml_next = rlast_reg;
                    st_next = S_IDLE;
                end
            end
            S_APLEN: begin
                cur_next = sc_reg[ST_W-1:0];
                len_we = 1'b1;
                len_wa = sc_reg[ST_W-1:0];
                len_wd = {1'b1, len_rd[LEN_W-1:0] + 1'b1};
                sc_next = sc_reg + 1'b1;
                u_next = last_reg;
                trans_ra = last_reg;
                link_ra = last_reg;
                st_next = S_W1;
            end
            S_W1: begin
                if (trans_rd[let_reg] != '0) begin
                    v_next = trans_rd[let_reg];
                    len_ra = trans_rd[let_reg];
                    st_next = S_HIT2;
                end else begin
                    trans_we = 1'b1;
                    trans_wa = u_reg;
                    trans_wd = trans_rd;
                    trans_wd[let_reg] = cur_reg;
                    if (u_reg == '0) begin
                        link_we = 1'b1;
                        link_wa = cur_reg;
                        st_next = S_APEND;
                    end else begin
                        u_next = link_rd;
                        trans_ra = link_rd;
                        link_ra = link_rd;
                    end
                end
            end
            S_HIT2: begin
                lenv_next = len_rd[LEN_W-1:0];
                len_ra = u_reg;
                st_next = S_HIT3;
            end
            S_HIT3: begin
                if (lenv_reg == len_rd[LEN_W-1:0] + 1'b1) begin
                    link_we = 1'b1;
                    link_wa = cur_reg;
                    link_wd = v_reg;
                    st_next = S_APEND;
                end else begin
                    w_next = sc_reg[ST_W-1:0];
                    sc_next = sc_reg + 1'b1;
                    len_we = 1'b1;
                    len_wa = sc_reg[ST_W-1:0];
                    len_wd = {1'b0, len_rd[LEN_W-1:0] + 1'b1};
                    link_ra = v_reg;
                    trans_ra = v_reg;
                    st_next = S_CL2;
                end
            end
            S_CL2: begin
                link_we = 1'b1;
                link_wa = w_reg;
                link_wd = link_rd;
                trans_we = 1'b1;
                trans_wa = w_reg;
                trans_wd = trans_rd;
                trans_ra = u_reg;
                link_ra = u_reg;
                st_next = S_R2;
            end
            S_R2: begin
                if (trans_rd[let_reg] != v_reg) begin
                    st_next = S_CLF;
                end else begin
                    trans_we = 1'b1;
                    trans_wa = u_reg;
                    trans_wd = trans_rd;
                    trans_wd[let_reg] = w_reg;
                    if (u_reg == '0) begin
                        st_next = S_CLF;
                    end else begin
                        u_next = link_rd;
                        trans_ra = link_rd;
                        link_ra = link_rd;
                    end
                end
            end
            S_CLF: begin
                link_we = 1'b1;
                link_wa = cur_reg;
                link_wd = w_reg;
                st_next = S_CLF2;
            end
            S_CLF2: begin
                link_we = 1'b1;
                link_wa = v_reg;
                link_wd = w_reg;
                st_next = S_APEND;
            end
            S_APEND: begin
                last_next = cur_reg;
                tl_next = tl_reg + 1'b1;
                stale_next = 1'b1;
                qact_next = 1'b0;
                st_next = S_DONE;
            end
            S_BCLR: begin
                bkt_we = 1'b1;
                bkt_wa = idx_reg[BKT_AW-1:0];
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SC_W'(BKT_N - 1)) begin
                    idx_next = '0;
                    st_next = S_BLEN;
                end
            end
            S_BLEN: begin
                len_ra = idx_reg[ST_W-1:0];
                st_next = S_BBRD;
            end
            S_BBRD: begin
                bkt_ra = BKT_AW'(len_rd[LEN_W-1:0]) + 1'b1;
                u_next = ST_W'(len_rd[LEN_W-1:0]) + 1'b1;
                st_next = S_BBWR;
            end
            S_BBWR: begin
                bkt_we = 1'b1;
                bkt_wa = BKT_AW'(u_reg);
                bkt_wd = bkt_rd + 1'b1;
                if (idx_reg + 1'b1 == sc_reg) begin
                    idx_next = '0;
                    run_next = '0;
                    st_next = S_PRD;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    st_next = S_BLEN;
                end
            end
            S_PRD: begin
                bkt_ra = idx_reg[BKT_AW-1:0];
                st_next = S_PWR;
            end
            S_PWR: begin
                bkt_we = 1'b1;
                bkt_wa = idx_reg[BKT_AW-1:0];
                bkt_wd = psum;
                run_next = psum;
                if (idx_reg == SC_W'(BKT_N - 1)) begin
                    idx_next = '0;
                    st_next = S_OLEN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    st_next = S_PRD;
                end
            end
            S_OLEN: begin
                len_ra = idx_reg[ST_W-1:0];
                st_next = S_OBRD;
            end
            S_OBRD: begin
                bkt_ra = BKT_AW'(len_rd[LEN_W-1:0]);
                u_next = ST_W'(len_rd[LEN_W-1:0]);
                st_next = S_OWR;
            end
            S_OWR: begin
                ord_we = 1'b1;
                ord_wa = bkt_rd[ST_W-1:0];
                ord_wd = idx_reg[ST_W-1:0];
                bkt_we = 1'b1;
                bkt_wa = BKT_AW'(u_reg);
                bkt_wd = bkt_rd + 1'b1;
                if (idx_reg + 1'b1 == sc_reg) begin
                    idx_next = '0;
                    st_next = S_ILEN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    st_next = S_OLEN;
                end
            end
            S_ILEN: begin
                len_ra = idx_reg[ST_W-1:0];
                st_next = S_IWR;
            end
            S_IWR: begin
                occ_we = 1'b1;
                occ_wa = idx_reg[ST_W-1:0];
                occ_wd = LEN_W'(len_rd[LEN_W]);
                if (idx_reg + 1'b1 == sc_reg) begin
                    if (sc_reg == SC_W'(1)) begin
                        idx_next = sc_reg;
                        st_next = S_TORD;
                    end else begin
                        st_next = S_CORD;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    st_next = S_ILEN;
                end
            end
            S_CORD: begin
                ord_ra = idx_reg[ST_W-1:0];
                st_next = S_COCC;
            end
            S_COCC: begin
                occ_ra = ord_rd;
                link_ra = ord_rd;
                st_next = S_CLNK;
            end
            S_CLNK: begin
                occu_next = occ_rd;
                lnk_next = link_rd;
                occ_ra = link_rd;
                st_next = S_CWR;
            end
            S_CWR: begin
                occ_we = 1'b1;
                occ_wa = lnk_reg;
                occ_wd = occ_rd + occu_reg;
                if (idx_reg == SC_W'(1)) begin
                    idx_next = sc_reg;
                    st_next = S_TORD;
                end else begin
                    idx_next = idx_reg - 1'b1;
                    st_next = S_CORD;
                end
            end
            S_TORD: begin
                ord_ra = idx_reg[ST_W-1:0] - 1'b1;
                st_next = S_TROW;
            end
            S_TROW: begin
                u_next = ord_rd;
                occ_ra = ord_rd;
                trans_ra = ord_rd;
                st_next = S_TINI;
            end
            S_TINI: begin
                row_next = trans_rd;
                if (u_reg == '0) begin
                    acc_next = '0;
                end else if (mode_reg) begin
                    acc_next = RANK_W'(1);
                end else begin
                    acc_next = RANK_W'(occ_rd);
                end
                c_next = '0;
                st_next = S_TLP;
            end
            S_TLP: begin
                if (c_reg == LET_W'(sa_kth_pkg::ALPHABET)) begin
                    path_we = 1'b1;
                    path_wa = u_reg;
                    path_wd = acc_reg;
                    if (idx_reg == SC_W'(1)) begin
                        stale_next = 1'b0;
                        st_next = S_QRD;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                        st_next = S_TORD;
                    end
                end else if (row_reg[c_reg] != '0) begin
                    path_ra = row_reg[c_reg];
                    st_next = S_TADD;
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end
            S_TADD: begin
                acc_next = acc_reg + path_rd;
                c_next = c_reg + 1'b1;
                st_next = S_TLP;
            end
            S_QRD: begin
                path_ra = '0;
                st_next = S_QCHK;
            end
            S_QCHK: begin
                if (rank_reg == '0 || rank_reg > path_rd) begin
                    rs_next = sa_kth_pkg::ST_NOSUCH;
                    qact_next = 1'b0;
                end else begin
                    qact_next = 1'b1;
                    qcur_next = '0;
                    qsum_next = '0;
                    qrank_next = rank_reg;
                end
                st_next = S_DONE;
            end
            S_NROW: begin
                row_next = trans_rd;
                c_next = '0;
                st_next = S_NLP;
            end
            S_NLP: begin
                if (c_reg == LET_W'(sa_kth_pkg::ALPHABET)) begin
                    rs_next = sa_kth_pkg::ST_NOSUCH;
                    qact_next = 1'b0;
                    st_next = S_DONE;
                end else if (row_reg[c_reg] != '0) begin
                    path_ra = row_reg[c_reg];
                    occ_ra = row_reg[c_reg];
                    v_next = row_reg[c_reg];
                    st_next = S_NCHK;
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end
            S_NCHK: begin
                if (sum1 < {1'b0, qrank_reg}) begin
                    qsum_next = sum1;
                    c_next = c_reg + 1'b1;
                    st_next = S_NLP;
                end else begin
                    qsum_next = sum2;
                    qcur_next = v_reg;
                    rs_next = sa_kth_pkg::ST_LETTER;
                    rl_next = c_reg;
                    if (sum2 >= {1'b0, qrank_reg}) begin
                        rlast_next = 1'b1;
                        qact_next = 1'b0;
                    end
                    st_next = S_DONE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase

        if (cfg_we) begin
            if (cfg_wdata != mode_reg) begin
                stale_next = 1'b1;
                qact_next = 1'b0;
            end
            mode_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_CLR;
            mode_reg <= 1'b0;
            tl_reg <= '0;
            sc_reg <= SC_W'(1);
            last_reg <= '0;
            stale_reg <= 1'b0;
            qcur_reg <= '0;
            qsum_reg <= '0;
            qrank_reg <= '0;
            qact_reg <= 1'b0;
            resp_reg <= 1'b0;
            idx_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            mode_reg <= mode_next;
            tl_reg <= tl_next;
            sc_reg <= sc_next;
            last_reg <= last_next;
            stale_reg <= stale_next;
            qcur_reg <= qcur_next;
            qsum_reg <= qsum_next;
            qrank_reg <= qrank_next;
            qact_reg <= qact_next;
            resp_reg <= resp_next;
            idx_reg <= idx_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        let_reg <= let_next;
        rank_reg <= rank_next;
        cur_reg <= cur_next;
        u_reg <= u_next;
        v_reg <= v_next;
        w_reg <= w_next;
        lenv_reg <= lenv_next;
        acc_reg <= acc_next;
        run_reg <= run_next;
        c_reg <= c_next;
        row_reg <= row_next;
        occu_reg <= occu_next;
        lnk_reg <= lnk_next;
        rs_reg <= rs_next;
        rl_reg <= rl_next;
        rlast_reg <= rlast_next;
        mu_reg <= mu_next;
        md_reg <= md_next;
        ml_reg <= ml_next;
    end

`ifndef NO_ASSERTIONS
    a_state_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_IDLE) |-> ({1'b0, sc_reg} <= ({2'b0, tl_reg} << 1) + 1'b1))
        else $error("state count exceeds bound for text length");

    a_query_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_IDLE && qact_reg) |-> !stale_reg)
        else $error("active query on stale counts");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new transaction taken while busy");
`endif

endmodule

`default_nettype wire
